>>> design/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is high
`define CHK_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");

// clocked assertion that also holds during reset
`define CHK_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

>>> design/dfsg_pkg.sv
// constants, state type and sine table builder for the sweep generator
// no dependencies
`default_nettype none

package dfsg_pkg;

  localparam int MAX_POINTS   = 2048;
  localparam int PT_W         = 12;
  localparam int CNT_W        = 11;
  localparam int FREQ_W       = 32;
  localparam int HZ_W         = 24;
  localparam int FRAC_BITS    = 8;
  localparam int RATIO_W      = 31;
  localparam int SINE_ADDR_W  = 10;
  localparam int SINE_DEPTH   = 1 << SINE_ADDR_W;
  localparam int SINE_W       = 16;
  localparam int SINE_PEAK    = 32767;
  localparam int DIV_W        = 48;
  localparam int DIVISOR_W    = 15;

  localparam logic [1:0] REG_FREQ_LOW  = 2'd0;
  localparam logic [1:0] REG_FREQ_HIGH = 2'd1;
  localparam logic [1:0] REG_MODE      = 2'd2;
  localparam logic [1:0] REG_RATIO     = 2'd3;

  localparam logic [2:0] MODE_RISE  = 3'd0;
  localparam logic [2:0] MODE_FALL  = 3'd1;
  localparam logic [2:0] MODE_TRI   = 3'd2;
  localparam logic [2:0] MODE_SINE  = 3'd3;
  localparam logic [2:0] MODE_LOG   = 3'd4;
  localparam logic [2:0] MODE_FIXED = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RESTART,
    ST_DIV_STEP,
    ST_DIV_PINC,
    ST_ADVANCE,
    ST_SIN_PH,
    ST_SIN_ROM,
    ST_SIN_MAG,
    ST_SIN_MUL,
    ST_SIN_DIV,
    ST_LOG,
    ST_OUT
  } state_t;

  typedef logic signed [SINE_W-1:0] sine_lut_t [SINE_DEPTH];

  function automatic logic signed [SINE_W-1:0] sine_entry(input int unsigned k);
    logic [63:0] u;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    logic [1:0]  quad;
    u = 64'(k) << (32 - SINE_ADDR_W);
    quad = u[31:30];
    r = {34'd0, u[29:0]};
    if (quad[0]) begin
      r = 64'd1073741824 - r;
    end
    x  = (r * 64'd1686629713) >> 30;
    x2 = (x * x) >> 30;
    t  = 64'd1073741824;
    t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd110;
    t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd72;
    t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd42;
    t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd20;
    t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    v  = (s * 64'(SINE_PEAK) + 64'd536870912) >> 30;
    if (v > 64'(SINE_PEAK)) begin
      v = 64'(SINE_PEAK);
    end
    return quad[1] ? -SINE_W'(v) : SINE_W'(v);
  endfunction

  function automatic sine_lut_t build_sine_lut();
    sine_lut_t lut;
    for (int i = 0; i < SINE_DEPTH; i++) begin
      lut[i] = sine_entry(i);
    end
    return lut;
  endfunction

endpackage

`default_nettype wire

>>> design/dds_frequency_sweep_generator.sv
// top level of the sweep generator: sequencer, bit-serial multiplier and divider, sine rom
// depends on dfsg_pkg
// in hold, rise, fall and triangle the sequencer goes straight from advance to output;
// past the first point, log mode adds a 31-step serial multiply and sine mode adds 11 + 15
// multiply steps, one rom read and 48 divide steps; a restart with freq_high above
// freq_low adds two 48-step serial divisions. one item at a time; next beat accepted after the result
// is registered. synchronous reset clears control state and loads register defaults
`default_nettype none

module dds_frequency_sweep_generator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // restart
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // frequency_q8, point_number
  output logic             m_tlast,   // sweep_end
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam dfsg_pkg::sine_lut_t SINE_LUT = dfsg_pkg::build_sine_lut();

  dfsg_pkg::state_t state, state_next;

  logic [dfsg_pkg::HZ_W-1:0]    freq_low, freq_high;
  logic [2:0]                   sweep_mode;
  logic [dfsg_pkg::RATIO_W-1:0] log_ratio;

  logic [dfsg_pkg::PT_W-1:0]    point_total;
  logic [dfsg_pkg::HZ_W-1:0]    step_size;
  logic [31:0]                  phase_increment;
  logic [dfsg_pkg::FREQ_W-1:0]  running_frequency;
  logic [dfsg_pkg::CNT_W-1:0]   point_counter;
  logic                         restart;
  logic                         hold_r;

  logic [63:0]                  mul_a, mul_acc;
  logic [31:0]                  mul_b;
  logic [4:0]                   mul_cnt;
  logic [dfsg_pkg::DIV_W-1:0]   div_q;
  logic [dfsg_pkg::DIVISOR_W-1:0] div_rem, div_dsr;
  logic [5:0]                   div_cnt;
  logic [dfsg_pkg::DIVISOR_W:0] div_t;

  logic [dfsg_pkg::SINE_ADDR_W-1:0] rom_addr;
  logic signed [dfsg_pkg::SINE_W-1:0] rom_q;
  logic                         sin_neg;

  logic [dfsg_pkg::FREQ_W-1:0]  freq_out;
  logic [dfsg_pkg::CNT_W-1:0]   pnum_out;
  logic                         last_out;

  logic [dfsg_pkg::HZ_W-1:0]    span;
  logic                         span_ok;
  logic [dfsg_pkg::PT_W-1:0]    pt_val;
  logic                         hold;
  logic [dfsg_pkg::PT_W-1:0]    cnt_inc;
  logic [dfsg_pkg::CNT_W-1:0]   cnt_new;
  logic [31:0]                  step_q8;
  logic [32:0]                  ramp_sum;
  logic [31:0]                  ramp_val;
  logic                         rising;
  logic [31:0]                  start_val;
  logic [31:0]                  phase;
  logic [30:0]                  half_span;
  logic [33:0]                  sine_base, sine_val;
  logic [63:0]                  log_sum;
  logic [14:0]                  sin_mag;
  logic                         out_free;

  always_comb begin
    span      = freq_high - freq_low;
    span_ok   = freq_high > freq_low;
    pt_val    = (span < dfsg_pkg::HZ_W'(dfsg_pkg::MAX_POINTS)) ?
                span[dfsg_pkg::PT_W-1:0] : dfsg_pkg::PT_W'(dfsg_pkg::MAX_POINTS);
    hold      = (sweep_mode >= dfsg_pkg::MODE_FIXED) || !span_ok || (point_total == '0);
    cnt_inc   = {1'b0, point_counter} + 12'd1;
    if (restart || (cnt_inc >= point_total)) begin
      cnt_new = '0;
    end else begin
      cnt_new = cnt_inc[dfsg_pkg::CNT_W-1:0];
    end
    step_q8   = {step_size, 8'd0};
    case (sweep_mode)
      dfsg_pkg::MODE_RISE: rising = 1'b1;
      dfsg_pkg::MODE_FALL: rising = 1'b0;
      default:             rising = {1'b0, cnt_new} <= (point_total >> 1);
    endcase
    ramp_sum  = {1'b0, running_frequency} + {1'b0, step_q8};
    if (rising) begin
      ramp_val = ramp_sum[32] ? '1 : ramp_sum[31:0];
    end else begin
      ramp_val = (running_frequency >= step_q8) ? running_frequency - step_q8 : '0;
    end
    start_val = (sweep_mode == dfsg_pkg::MODE_FALL) ? {freq_high, 8'd0} : {freq_low, 8'd0};
    phase     = mul_acc[31:0] - 32'h4000_0000;
    half_span = 31'({span, 8'd0} >> 1);
    sine_base = {2'd0, freq_low, 8'd0} + {3'd0, half_span};
    sine_val  = sin_neg ? sine_base - {2'd0, div_q[31:0]} : sine_base + {2'd0, div_q[31:0]};
    log_sum   = mul_acc + 64'h2000_0000;
    sin_mag   = rom_q[dfsg_pkg::SINE_W-1] ? 15'(-rom_q) : rom_q[14:0];
    div_t     = {div_rem, div_q[dfsg_pkg::DIV_W-1]};
    out_free  = !m_tvalid || m_tready;
  end

  always_comb begin
    state_next = state;
    case (state)
      dfsg_pkg::ST_IDLE:
        if (s_tvalid) begin
          state_next = s_tdata[0] ? dfsg_pkg::ST_RESTART : dfsg_pkg::ST_ADVANCE;
        end
      dfsg_pkg::ST_RESTART:
        state_next = span_ok ? dfsg_pkg::ST_DIV_STEP : dfsg_pkg::ST_ADVANCE;
      dfsg_pkg::ST_DIV_STEP:
        if (div_cnt == '0) state_next = dfsg_pkg::ST_DIV_PINC;
      dfsg_pkg::ST_DIV_PINC:
        if (div_cnt == '0) state_next = dfsg_pkg::ST_ADVANCE;
      dfsg_pkg::ST_ADVANCE:
        if (hold || cnt_new == '0) begin
          state_next = dfsg_pkg::ST_OUT;
        end else if (sweep_mode == dfsg_pkg::MODE_SINE) begin
          state_next = dfsg_pkg::ST_SIN_PH;
        end else if (sweep_mode == dfsg_pkg::MODE_LOG) begin
          state_next = dfsg_pkg::ST_LOG;
        end else begin
          state_next = dfsg_pkg::ST_OUT;
        end
      dfsg_pkg::ST_SIN_PH:
        if (mul_cnt == '0) state_next = dfsg_pkg::ST_SIN_ROM;
      dfsg_pkg::ST_SIN_ROM:
        state_next = dfsg_pkg::ST_SIN_MAG;
      dfsg_pkg::ST_SIN_MAG:
        state_next = dfsg_pkg::ST_SIN_MUL;
      dfsg_pkg::ST_SIN_MUL:
        if (mul_cnt == '0) state_next = dfsg_pkg::ST_SIN_DIV;
      dfsg_pkg::ST_SIN_DIV:
        if (div_cnt == '0) state_next = dfsg_pkg::ST_OUT;
      dfsg_pkg::ST_LOG:
        if (mul_cnt == '0) state_next = dfsg_pkg::ST_OUT;
      dfsg_pkg::ST_OUT:
        if (out_free) state_next = dfsg_pkg::ST_IDLE;
      default:
        state_next = dfsg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = (state == dfsg_pkg::ST_IDLE);
    cfg_ready = 1'b1;
    m_tdata   = {5'd0, pnum_out, freq_out};
    m_tlast   = last_out;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dfsg_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // registers and sweep state
  always_ff @(posedge clk) begin
    if (rst) begin
      freq_low          <= 24'd1000;
      freq_high         <= 24'd100000;
      sweep_mode        <= dfsg_pkg::MODE_FIXED;
      log_ratio         <= 31'h4000_0000;
      point_total       <= '0;
      step_size         <= '0;
      phase_increment   <= '0;
      running_frequency <= '0;
      point_counter     <= '0;
      m_tvalid          <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          dfsg_pkg::REG_FREQ_LOW:  freq_low   <= cfg_data[dfsg_pkg::HZ_W-1:0];
          dfsg_pkg::REG_FREQ_HIGH: freq_high  <= cfg_data[dfsg_pkg::HZ_W-1:0];
          dfsg_pkg::REG_MODE:      sweep_mode <= cfg_data[2:0];
          dfsg_pkg::REG_RATIO:     log_ratio  <= cfg_data[dfsg_pkg::RATIO_W-1:0];
          default:                 log_ratio  <= log_ratio;
        endcase
      end
      if (state == dfsg_pkg::ST_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        dfsg_pkg::ST_RESTART:
          if (span_ok) begin
            point_total <= pt_val;
          end else begin
            point_total     <= '0;
            step_size       <= '0;
            phase_increment <= '0;
          end
        dfsg_pkg::ST_DIV_STEP:
          if (div_cnt == '0) begin
            step_size <= (sweep_mode == dfsg_pkg::MODE_TRI) ?
                         {div_q[dfsg_pkg::HZ_W-2:0], 1'b0} : div_q[dfsg_pkg::HZ_W-1:0];
          end
        dfsg_pkg::ST_DIV_PINC:
          if (div_cnt == '0) phase_increment <= div_q[31:0];
        dfsg_pkg::ST_ADVANCE:
          if (hold) begin
            point_counter     <= '0;
            running_frequency <= {freq_low, 8'd0};
          end else begin
            point_counter <= cnt_new;
            if (cnt_new == '0) begin
              running_frequency <= start_val;
            end else if (sweep_mode != dfsg_pkg::MODE_SINE && sweep_mode != dfsg_pkg::MODE_LOG) begin
              running_frequency <= ramp_val;
            end
          end
        dfsg_pkg::ST_SIN_DIV:
          if (div_cnt == '0) begin
            running_frequency <= (sine_val[33:32] != 2'd0) ? '1 : sine_val[31:0];
          end
        dfsg_pkg::ST_LOG:
          if (mul_cnt == '0) begin
            running_frequency <= (log_sum[63:62] != 2'd0) ? '1 : log_sum[61:30];
          end
        default: ;
      endcase
    end
  end

  // serial multiplier, divider, rom and result payload
  always_ff @(posedge clk) begin
    rom_q <= SINE_LUT[rom_addr];
    case (state)
      dfsg_pkg::ST_IDLE:
        restart <= s_tdata[0];
      dfsg_pkg::ST_RESTART: begin
        div_q   <= {24'd0, span};
        div_dsr <= {3'd0, pt_val};
        div_rem <= '0;
        div_cnt <= 6'(dfsg_pkg::DIV_W);
      end
      dfsg_pkg::ST_ADVANCE: begin
        hold_r  <= hold;
        mul_acc <= '0;
        if (sweep_mode == dfsg_pkg::MODE_SINE) begin
          mul_a   <= {32'd0, phase_increment};
          mul_b   <= {21'd0, cnt_new};
          mul_cnt <= 5'(dfsg_pkg::CNT_W);
        end else begin
          mul_a   <= {32'd0, running_frequency};
          mul_b   <= {1'b0, log_ratio};
          mul_cnt <= 5'(dfsg_pkg::RATIO_W);
        end
      end
      dfsg_pkg::ST_SIN_MAG: begin
        sin_neg <= rom_q[dfsg_pkg::SINE_W-1];
        mul_a   <= {33'd0, half_span};
        mul_b   <= {17'd0, sin_mag};
        mul_acc <= '0;
        mul_cnt <= 5'd15;
      end
      dfsg_pkg::ST_OUT: begin
        if (out_free) begin
          freq_out <= running_frequency;
          pnum_out <= hold_r ? '0 : point_counter;
          last_out <= !hold_r && ({1'b0, point_counter} == point_total - 12'd1);
        end
      end
      default: ;
    endcase
    if (state == dfsg_pkg::ST_SIN_PH || state == dfsg_pkg::ST_SIN_MUL ||
        state == dfsg_pkg::ST_LOG) begin
      if (mul_cnt != '0) begin
        if (mul_b[0]) mul_acc <= mul_acc + mul_a;
        mul_a   <= mul_a << 1;
        mul_b   <= mul_b >> 1;
        mul_cnt <= mul_cnt - 5'd1;
      end else if (state == dfsg_pkg::ST_SIN_PH) begin
        rom_addr <= phase[31 -: dfsg_pkg::SINE_ADDR_W];
      end else if (state == dfsg_pkg::ST_SIN_MUL) begin
        div_q   <= mul_acc[dfsg_pkg::DIV_W-1:0] + 48'd16383;
        div_dsr <= 15'(dfsg_pkg::SINE_PEAK);
        div_rem <= '0;
        div_cnt <= 6'(dfsg_pkg::DIV_W);
      end
    end
    if (state == dfsg_pkg::ST_DIV_STEP || state == dfsg_pkg::ST_DIV_PINC ||
        state == dfsg_pkg::ST_SIN_DIV) begin
      if (div_cnt != '0) begin
        if (div_t >= {1'b0, div_dsr}) begin
          div_rem <= 15'(div_t - {1'b0, div_dsr});
          div_q   <= {div_q[dfsg_pkg::DIV_W-2:0], 1'b1};
        end else begin
          div_rem <= div_t[dfsg_pkg::DIVISOR_W-1:0];
          div_q   <= {div_q[dfsg_pkg::DIV_W-2:0], 1'b0};
        end
        div_cnt <= div_cnt - 6'd1;
      end else if (state == dfsg_pkg::ST_DIV_STEP) begin
        div_q   <= 48'h1_0000_0000;
        div_rem <= '0;
        div_cnt <= 6'(dfsg_pkg::DIV_W);
      end
    end
  end

endmodule

`default_nettype wire

>>> design/dfsg_checker.sv
// port-level checks for the sweep generator, bound to the top level
// depends on assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module dfsg_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [47:0] m_tdata,
  input wire logic        m_tlast
);

  `CHK_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid)
  `CHK_ASSERT(a_out_stable, clk, rst, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
  `CHK_ASSERT(a_one_at_a_time, clk, rst, s_tvalid && s_tready |=> !s_tready)
  `CHK_ASSERT(a_pad_zero, clk, rst, m_tvalid |-> m_tdata[47:43] == 5'd0)
  `CHK_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_tvalid)

endmodule

bind dds_frequency_sweep_generator dfsg_checker u_dfsg_checker (.*);

`default_nettype wire
